FILE: rtl/lec_pkg.sv
// Shared types, constants and codes of the leader election controller.
`timescale 1ns / 1ps
`default_nettype none

package lec_pkg;

  localparam int TICK_COUNTER_BITS = 16;
  localparam int CFG_TIME_W        = 16;
  localparam int CMP_W             = (TICK_COUNTER_BITS > CFG_TIME_W) ?
                                     TICK_COUNTER_BITS : CFG_TIME_W;

  localparam int ID_W    = 32;
  localparam int MAC_W   = 48;
  localparam int REP_W   = 4;
  localparam int BYTE_W  = 8;
  localparam int ACT_W   = 2;
  localparam int CIDX_W  = 3;
  localparam int CDATA_W = 48;

  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 16;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [BYTE_W-1:0] MAGIC_BYTE    = 8'h56;
  localparam logic [BYTE_W-1:0] TYPE_CLAIM    = 8'h01;
  localparam logic [BYTE_W-1:0] TYPE_RESULT   = 8'h03;
  localparam logic [BYTE_W-1:0] MIN_FRAME_LEN = 8'd12;

  localparam logic [CFG_TIME_W-1:0] RST_ELECTION_TIMEOUT = 16'd3000;
  localparam logic [CFG_TIME_W-1:0] RST_CLAIM_INTERVAL   = 16'd200;
  localparam logic [REP_W-1:0]      RST_RESULT_REPEATS   = 4'd5;
  localparam logic [CFG_TIME_W-1:0] RST_ANNOUNCE_GAP     = 16'd100;
  localparam logic [CFG_TIME_W-1:0] RST_SLAVE_WAIT       = 16'd1000;

  typedef logic [TICK_COUNTER_BITS-1:0] cnt_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_TICK  = 2'd0,
    ACT_FRAME = 2'd1,
    ACT_START = 2'd2,
    ACT_SPARE = 2'd3
  } action_t;

  typedef enum logic [CIDX_W-1:0] {
    REG_OWN_ID           = 3'd0,
    REG_OWN_MAC          = 3'd1,
    REG_ELECTION_TIMEOUT = 3'd2,
    REG_CLAIM_INTERVAL   = 3'd3,
    REG_RESULT_REPEATS   = 3'd4,
    REG_ANNOUNCE_GAP     = 3'd5,
    REG_SLAVE_WAIT       = 3'd6,
    REG_UNUSED           = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_ELECT    = 3'd1,
    PH_ANNOUNCE = 3'd2,
    PH_SLAVE    = 3'd3,
    PH_DONE     = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    ROLE_NONE   = 2'd0,
    ROLE_MASTER = 2'd1,
    ROLE_SLAVE  = 2'd2
  } role_t;

  typedef enum logic [1:0] {
    REQ_NONE   = 2'd0,
    REQ_CLAIM  = 2'd1,
    REQ_RESULT = 2'd2
  } send_t;

  // Event classes produced by the front end.
  typedef enum logic [2:0] {
    EV_NOP          = 3'd0,
    EV_TICK         = 3'd1,
    EV_START        = 3'd2,
    EV_YIELD        = 3'd3,
    EV_RESULT_OTHER = 3'd4,
    EV_RESULT_US    = 3'd5
  } ev_kind_t;

  typedef struct packed {
    logic [CFG_TIME_W-1:0] election_timeout;
    logic [CFG_TIME_W-1:0] claim_interval;
    logic [REP_W-1:0]      result_repeats;
    logic [CFG_TIME_W-1:0] announce_gap;
    logic [CFG_TIME_W-1:0] slave_wait;
  } timing_cfg_t;

  typedef struct packed {
    logic   finished;
    logic   won;
    logic   got_result;
    logic   yielded;
    role_t  role;
    phase_t phase;
    send_t  send_kind;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/lec_front.sv
// Front end: classifies each accepted input item into an election event.
`timescale 1ns / 1ps
`default_nettype none

module lec_front (
  input  wire logic [lec_pkg::ACT_W-1:0]  action,
  input  wire logic [lec_pkg::BYTE_W-1:0] frame_magic,
  input  wire logic [lec_pkg::BYTE_W-1:0] frame_type,
  input  wire logic [lec_pkg::BYTE_W-1:0] frame_length,
  input  wire logic [lec_pkg::ID_W-1:0]   peer_id,
  input  wire logic [lec_pkg::MAC_W-1:0]  peer_mac,
  input  wire logic [lec_pkg::ID_W-1:0]   own_id,
  input  wire logic [lec_pkg::MAC_W-1:0]  own_mac,
  output lec_pkg::ev_kind_t               ev_kind
);
  import lec_pkg::*;

  logic frame_ok;
  logic mac_is_ours;
  logic outranks;

  assign frame_ok    = (frame_magic == MAGIC_BYTE) && (frame_length >= MIN_FRAME_LEN);
  assign mac_is_ours = (peer_mac == own_mac);
  assign outranks    = {peer_id, peer_mac} > {own_id, own_mac};

  always_comb begin
    ev_kind = EV_NOP;
    case (action_t'(action))
      ACT_TICK:  ev_kind = EV_TICK;
      ACT_START: ev_kind = EV_START;
      ACT_FRAME: begin
        if (frame_ok && frame_type == TYPE_CLAIM) begin
          if (!mac_is_ours && outranks) begin
            ev_kind = EV_YIELD;
          end
        end else if (frame_ok && frame_type == TYPE_RESULT) begin
          ev_kind = mac_is_ours ? EV_RESULT_US : EV_RESULT_OTHER;
        end
      end
      default: ev_kind = EV_NOP;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/lec_queue.sv
// Short event queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module lec_queue (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire lec_pkg::ev_kind_t push_kind,
  output logic            full,
  input  wire logic       pop,
  output logic            not_empty,
  output lec_pkg::ev_kind_t head_kind
);
  import lec_pkg::*;

  ev_kind_t                entry_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]      count_r, count_nxt;

  function automatic logic [Q_PTR_W-1:0] ptr_inc(input logic [Q_PTR_W-1:0] p);
    ptr_inc = (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full      = (count_r == Q_CNT_W'(Q_DEPTH));
  assign not_empty = (count_r != '0);
  assign head_kind = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_kind;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lec_back.sv
// Back end: election state machine, counters and the registered result stage.
`timescale 1ns / 1ps
`default_nettype none

module lec_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire lec_pkg::timing_cfg_t cfg,
  input  wire logic          ev_valid,
  input  wire lec_pkg::ev_kind_t ev_kind,
  output logic               ev_pop,
  output logic               res_valid,
  output lec_pkg::result_t   res_data,
  input  wire logic          res_ready
);
  import lec_pkg::*;

  phase_t      phase_r, phase_nxt;
  role_t       role_r, role_nxt;
  cnt_t        elapsed_r, elapsed_nxt;
  cnt_t        wait_r, wait_nxt;
  logic [REP_W-1:0] repeats_r, repeats_nxt;
  logic        yielded_r, yielded_nxt;
  logic        result_r, result_nxt;
  logic        won_r, won_nxt;
  logic        out_valid_r;
  result_t     out_data_r, out_data_nxt;
  send_t       send;
  logic        fin;

  function automatic cnt_t sat_inc(input cnt_t v);
    sat_inc = (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic logic reached(input cnt_t v, input logic [CFG_TIME_W-1:0] lim);
    reached = CMP_W'(v) >= CMP_W'(lim);
  endfunction

  assign ev_pop    = ev_valid && (!out_valid_r || res_ready);
  assign res_valid = out_valid_r;
  assign res_data  = out_data_r;

  always_comb begin
    phase_nxt   = phase_r;
    role_nxt    = role_r;
    elapsed_nxt = elapsed_r;
    wait_nxt    = wait_r;
    repeats_nxt = repeats_r;
    yielded_nxt = yielded_r;
    result_nxt  = result_r;
    won_nxt     = won_r;
    send        = REQ_NONE;
    fin         = 1'b0;

    case (ev_kind)
      EV_START: begin
        phase_nxt   = PH_ELECT;
        role_nxt    = ROLE_NONE;
        yielded_nxt = 1'b0;
        result_nxt  = 1'b0;
        won_nxt     = 1'b0;
        repeats_nxt = '0;
        elapsed_nxt = '0;
        wait_nxt    = '0;
        if (cfg.election_timeout == '0) begin
          phase_nxt   = PH_ANNOUNCE;
          role_nxt    = ROLE_MASTER;
          repeats_nxt = (cfg.result_repeats != '0) ? cfg.result_repeats - 1'b1 : '0;
          send        = REQ_RESULT;
        end else begin
          send = REQ_CLAIM;
        end
      end
      EV_YIELD, EV_RESULT_OTHER, EV_RESULT_US: begin
        if (phase_r == PH_ELECT || phase_r == PH_ANNOUNCE || phase_r == PH_SLAVE) begin
          if (ev_kind == EV_YIELD) begin
            yielded_nxt = 1'b1;
          end else if (ev_kind == EV_RESULT_OTHER) begin
            result_nxt = 1'b1;
          end else begin
            won_nxt = 1'b1;
          end
          if (phase_r == PH_ELECT && (yielded_nxt || result_nxt)) begin
            role_nxt = ROLE_SLAVE;
            wait_nxt = '0;
            if (result_nxt || cfg.slave_wait == '0) begin
              phase_nxt = PH_DONE;
              fin       = 1'b1;
            end else begin
              phase_nxt = PH_SLAVE;
            end
          end else if (phase_r == PH_SLAVE && result_nxt) begin
            phase_nxt = PH_DONE;
            fin       = 1'b1;
          end
        end
      end
      EV_TICK: begin
        case (phase_r)
          PH_ELECT: begin
            elapsed_nxt = sat_inc(elapsed_r);
            wait_nxt    = sat_inc(wait_r);
            if (reached(elapsed_nxt, cfg.election_timeout)) begin
              phase_nxt   = PH_ANNOUNCE;
              role_nxt    = ROLE_MASTER;
              repeats_nxt = (cfg.result_repeats != '0) ? cfg.result_repeats - 1'b1 : '0;
              wait_nxt    = '0;
              send        = REQ_RESULT;
            end else if (reached(wait_nxt, cfg.claim_interval)) begin
              send     = REQ_CLAIM;
              wait_nxt = '0;
            end
          end
          PH_ANNOUNCE: begin
            wait_nxt = sat_inc(wait_r);
            if (reached(wait_nxt, cfg.announce_gap)) begin
              wait_nxt = '0;
              if (repeats_r != '0) begin
                repeats_nxt = repeats_r - 1'b1;
                send        = REQ_RESULT;
              end else begin
                phase_nxt = PH_DONE;
                fin       = 1'b1;
              end
            end
          end
          PH_SLAVE: begin
            wait_nxt = sat_inc(wait_r);
            if (reached(wait_nxt, cfg.slave_wait)) begin
              phase_nxt = PH_DONE;
              fin       = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase

    out_data_nxt.send_kind  = send;
    out_data_nxt.phase      = phase_nxt;
    out_data_nxt.role       = role_nxt;
    out_data_nxt.yielded    = yielded_nxt;
    out_data_nxt.got_result = result_nxt;
    out_data_nxt.won        = won_nxt;
    out_data_nxt.finished   = fin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      role_r      <= ROLE_NONE;
      elapsed_r   <= '0;
      wait_r      <= '0;
      repeats_r   <= '0;
      yielded_r   <= 1'b0;
      result_r    <= 1'b0;
      won_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ev_pop) begin
        phase_r   <= phase_nxt;
        role_r    <= role_nxt;
        elapsed_r <= elapsed_nxt;
        wait_r    <= wait_nxt;
        repeats_r <= repeats_nxt;
        yielded_r <= yielded_nxt;
        result_r  <= result_nxt;
        won_r     <= won_nxt;
      end
      if (ev_pop) begin
        out_valid_r <= 1'b1;
      end else if (res_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ev_pop) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/leader_election_controller.sv
// Top level of the leader election controller: configuration registers and stream ports.
`timescale 1ns / 1ps
`default_nettype none

// Bully-style leader election controller. Every input transfer carries one event
// (millisecond tick, received frame or start) and produces exactly one result
// transfer with the broadcast request and the election state after that event.
// The block takes one event per clock cycle while the queue has room and the
// output is not stalled: the front end classifies a frame in the cycle of its
// transfer and writes the event into a two-entry queue, and the back end updates
// the state machine and counters into an output register. An event passes the
// queue register and then the output register before out_tvalid rises. Configuration
// writes are always accepted and should be made only while no event is in flight.

module leader_election_controller (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // in_tdata: frame_magic[7:0], frame_type[15:8], frame_length[23:16],
  //           peer_id[55:24], peer_mac[103:56]
  input  wire logic [lec_pkg::IN_DATA_W-1:0]  in_tdata,
  // in_tuser: action[1:0]
  input  wire logic [lec_pkg::ACT_W-1:0]      in_tuser,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // out_tdata: send_kind[1:0], phase[4:2], role[6:5], yielded[7], got_result[8],
  //            won[9], finished[10], zero padding[15:11]
  output logic [lec_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [lec_pkg::CIDX_W-1:0]     cfg_index,
  input  wire logic [lec_pkg::CDATA_W-1:0]    cfg_data
);
  import lec_pkg::*;

  logic [ID_W-1:0]  own_id_r;
  logic [MAC_W-1:0] own_mac_r;
  timing_cfg_t      timing_r;

  ev_kind_t front_kind;
  ev_kind_t head_kind;
  logic     q_full;
  logic     q_not_empty;
  logic     q_pop;
  logic     push;
  result_t  res;

  assign cfg_ready = 1'b1;
  assign in_tready = !q_full;
  assign push      = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_id_r                  <= '0;
      own_mac_r                 <= '0;
      timing_r.election_timeout <= RST_ELECTION_TIMEOUT;
      timing_r.claim_interval   <= RST_CLAIM_INTERVAL;
      timing_r.result_repeats   <= RST_RESULT_REPEATS;
      timing_r.announce_gap     <= RST_ANNOUNCE_GAP;
      timing_r.slave_wait       <= RST_SLAVE_WAIT;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_OWN_ID:           own_id_r                  <= cfg_data[ID_W-1:0];
        REG_OWN_MAC:          own_mac_r                 <= cfg_data[MAC_W-1:0];
        REG_ELECTION_TIMEOUT: timing_r.election_timeout <= cfg_data[CFG_TIME_W-1:0];
        REG_CLAIM_INTERVAL:   timing_r.claim_interval   <= cfg_data[CFG_TIME_W-1:0];
        REG_RESULT_REPEATS:   timing_r.result_repeats   <= cfg_data[REP_W-1:0];
        REG_ANNOUNCE_GAP:     timing_r.announce_gap     <= cfg_data[CFG_TIME_W-1:0];
        REG_SLAVE_WAIT:       timing_r.slave_wait       <= cfg_data[CFG_TIME_W-1:0];
        default: begin
        end
      endcase
    end
  end

  lec_front u_front (
    .action       (in_tuser),
    .frame_magic  (in_tdata[7:0]),
    .frame_type   (in_tdata[15:8]),
    .frame_length (in_tdata[23:16]),
    .peer_id      (in_tdata[55:24]),
    .peer_mac     (in_tdata[103:56]),
    .own_id       (own_id_r),
    .own_mac      (own_mac_r),
    .ev_kind      (front_kind)
  );

  lec_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_kind (front_kind),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_kind (head_kind)
  );

  lec_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (timing_r),
    .ev_valid  (q_not_empty),
    .ev_kind   (head_kind),
    .ev_pop    (q_pop),
    .res_valid (out_tvalid),
    .res_data  (res),
    .res_ready (out_tready)
  );

  assign out_tdata = {(OUT_DATA_W - $bits(result_t))'(0), res};

endmodule

`default_nettype wire
